// ----- sv/price_level_order_book_core_defines.svh -----
// Assertion macros shared by the order book RTL.
`ifndef PRICE_LEVEL_ORDER_BOOK_CORE_DEFINES_SVH
`define PRICE_LEVEL_ORDER_BOOK_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PLOB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("order book check failed");
`define PLOB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("order book check failed");
`else
`define PLOB_ASSERT_IMP(lbl, ante, cons)
`define PLOB_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- sv/plob_pkg.sv -----
// Shared constants and types of the price level order book.
package plob_pkg;
    localparam int LEVELS      = 64;
    localparam int PRICE_BITS  = 24;
    localparam int QTY_BITS    = 20;
    localparam int TOTAL_BITS  = 32;
    localparam int CNT_BITS    = $clog2(LEVELS + 1);
    localparam int SPREAD_BITS = PRICE_BITS + 1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2
    } status_t;

    typedef struct packed {
        logic [PRICE_BITS-1:0] price;
        logic [TOTAL_BITS-1:0] total;
    } lvl_t;

    typedef struct packed {
        logic                  en;
        logic                  remove;
        logic                  is_bid;
        logic                  hit;
        logic                  close;
        logic                  full;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   qty;
    } cell_ctl_t;

    typedef struct packed {
        logic ahead;
        logic match;
        logic close_req;
    } cell_stat_t;
endpackage

// ----- sv/price_level_order_book_core.sv -----
// Order book top level: request staging, both side chains and the result register.
//
//   Port group  Dir  Content
//   s_axis      in   tuser: kind, side; tdata: price, quantity
//   m_axis      out  tdata: best_bid, best_ask, spread, bid_count, ask_count, status
//
// Each request is first staged, then the cell chain of its side inserts,
// updates or closes a level, which also loads the result register.
// A new request is taken while a result waits; the update stalls until the
// result register is free. Reset empties both sides at once.
`include "price_level_order_book_core_defines.svh"
module price_level_order_book_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,   // kind, side
    input  logic [47:0] s_axis_tdata,   // price, quantity
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata    // best_bid, best_ask, spread, bid_count,
                                        // ask_count, status
);
    localparam int PB = plob_pkg::PRICE_BITS;
    localparam int QB = plob_pkg::QTY_BITS;
    localparam int CB = plob_pkg::CNT_BITS;
    localparam int SB = plob_pkg::SPREAD_BITS;

    logic                busy_reg;
    logic                out_valid_reg;
    logic                kind_reg;
    logic                side_reg;
    logic [PB-1:0]       price_reg;
    logic [QB-1:0]       qty_reg;
    logic [PB-1:0]       bid_out_reg;
    logic [PB-1:0]       ask_out_reg;
    logic [SB-1:0]       spread_out_reg;
    logic [CB-1:0]       bid_cnt_out_reg;
    logic [CB-1:0]       ask_cnt_out_reg;
    plob_pkg::status_t   status_out_reg;

    logic                exec;
    logic                bid_hit, bid_full, ask_hit, ask_full, hit, full;
    logic [CB-1:0]       bid_cnt_next, ask_cnt_next;
    logic [PB-1:0]       bid_best_next, ask_best_next;
    logic [SB-1:0]       spread_next;
    plob_pkg::status_t   status_next;

    assign s_axis_tready = !busy_reg;
    assign exec          = busy_reg && (!out_valid_reg || m_axis_tready);

    plob_side u_bid
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (exec && side_reg),
        .remove     (kind_reg),
        .is_bid     (1'b1),
        .price      (price_reg),
        .qty        (qty_reg),
        .hit        (bid_hit),
        .full       (bid_full),
        .count_next (bid_cnt_next),
        .best_next  (bid_best_next)
    );

    plob_side u_ask
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (exec && !side_reg),
        .remove     (kind_reg),
        .is_bid     (1'b0),
        .price      (price_reg),
        .qty        (qty_reg),
        .hit        (ask_hit),
        .full       (ask_full),
        .count_next (ask_cnt_next),
        .best_next  (ask_best_next)
    );

    assign hit  = side_reg ? bid_hit : ask_hit;
    assign full = side_reg ? bid_full : ask_full;

    always_comb
    begin
        status_next = plob_pkg::ST_OK;
        if (!hit)
        begin
            if (kind_reg)
            begin
                status_next = plob_pkg::ST_ABSENT;
            end
            else if (full)
            begin
                status_next = plob_pkg::ST_FULL;
            end
        end
    end

    assign spread_next = (bid_best_next == '0 || ask_best_next == '0) ? '0
                       : ({1'b0, ask_best_next} - {1'b0, bid_best_next});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                busy_reg <= 1'b1;
            end
            else if (exec)
            begin
                busy_reg <= 1'b0;
            end
            if (exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            kind_reg  <= s_axis_tuser[0];
            side_reg  <= s_axis_tuser[1];
            price_reg <= s_axis_tdata[PB-1:0];
            qty_reg   <= s_axis_tdata[PB+QB-1:PB];
        end
        if (exec)
        begin
            bid_out_reg     <= bid_best_next;
            ask_out_reg     <= ask_best_next;
            spread_out_reg  <= spread_next;
            bid_cnt_out_reg <= bid_cnt_next;
            ask_cnt_out_reg <= ask_cnt_next;
            status_out_reg  <= status_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, status_out_reg, ask_cnt_out_reg, bid_cnt_out_reg,
                            spread_out_reg, ask_out_reg, bid_out_reg};

    `PLOB_ASSERT_NXT(a_exec_frees, exec, !busy_reg)
    `PLOB_ASSERT_NXT(a_exec_result, exec, out_valid_reg)
    `PLOB_ASSERT_IMP(a_spread_zero, out_valid_reg && bid_out_reg == '0, spread_out_reg == '0)
    `PLOB_ASSERT_IMP(a_count_max, out_valid_reg,
                     bid_cnt_out_reg <= CB'(plob_pkg::LEVELS)
                     && ask_cnt_out_reg <= CB'(plob_pkg::LEVELS))
endmodule

// ----- sv/plob_cell.sv -----
// One price level cell of a sorted side chain.
module plob_cell
(
    input  logic               clk,
    input  plob_pkg::cell_ctl_t ctl,
    input  logic               occupied,
    input  logic               left_ahead,
    input  plob_pkg::lvl_t     left_lvl,
    input  plob_pkg::lvl_t     right_lvl,
    output plob_pkg::cell_stat_t stat,
    output plob_pkg::lvl_t     lvl,
    output plob_pkg::lvl_t     lvl_next
);
    plob_pkg::lvl_t                    lvl_reg;
    logic [plob_pkg::TOTAL_BITS:0]     sum;
    logic [plob_pkg::TOTAL_BITS-1:0]   qty_ext;

    assign lvl     = lvl_reg;
    assign qty_ext = {{(plob_pkg::TOTAL_BITS - plob_pkg::QTY_BITS){1'b0}}, ctl.qty};
    assign sum     = {1'b0, lvl_reg.total} + {1'b0, qty_ext};

    // A cell is ahead when it holds a better price than the request.
    assign stat.ahead = occupied && (ctl.is_bid ? (lvl_reg.price > ctl.price)
                                                : (lvl_reg.price < ctl.price));
    assign stat.match     = occupied && (lvl_reg.price == ctl.price);
    assign stat.close_req = stat.match && (qty_ext >= lvl_reg.total);

    always_comb
    begin
        lvl_next = lvl_reg;
        if (ctl.en)
        begin
            if (!ctl.remove)
            begin
                if (ctl.hit)
                begin
                    if (stat.match)
                    begin
                        lvl_next.total = sum[plob_pkg::TOTAL_BITS] ? '1
                                       : sum[plob_pkg::TOTAL_BITS-1:0];
                    end
                end
                else if (!ctl.full && !stat.ahead)
                begin
                    // The first cell not ahead takes the new level; the rest shift down.
                    if (left_ahead)
                    begin
                        lvl_next.price = ctl.price;
                        lvl_next.total = qty_ext;
                    end
                    else
                    begin
                        lvl_next = left_lvl;
                    end
                end
            end
            else if (ctl.close)
            begin
                if (!stat.ahead)
                begin
                    lvl_next = right_lvl;
                end
            end
            else if (stat.match)
            begin
                lvl_next.total = lvl_reg.total - qty_ext;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg <= lvl_next;
    end
endmodule

// ----- sv/plob_side.sv -----
// One side of the book: a sorted chain of level cells and its level count.
module plob_side
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            remove,
    input  logic                            is_bid,
    input  logic [plob_pkg::PRICE_BITS-1:0] price,
    input  logic [plob_pkg::QTY_BITS-1:0]   qty,
    output logic                            hit,
    output logic                            full,
    output logic [plob_pkg::CNT_BITS-1:0]   count_next,
    output logic [plob_pkg::PRICE_BITS-1:0] best_next
);
    localparam int L = plob_pkg::LEVELS;

    logic [plob_pkg::CNT_BITS-1:0] count_reg;
    plob_pkg::cell_ctl_t           ctl;
    plob_pkg::cell_stat_t          stat [L];
    plob_pkg::lvl_t                lvl [L];
    plob_pkg::lvl_t                lvl_nx [L];
    logic [L-1:0]                  match_vec;
    logic [L-1:0]                  close_vec;
    logic                          close;

    always_comb
    begin
        for (int j = 0; j < L; j++)
        begin
            match_vec[j] = stat[j].match;
            close_vec[j] = stat[j].close_req;
        end
    end

    assign hit   = |match_vec;
    assign close = |close_vec;
    assign full  = (count_reg == plob_pkg::CNT_BITS'(L));

    assign ctl.en     = en;
    assign ctl.remove = remove;
    assign ctl.is_bid = is_bid;
    assign ctl.hit    = hit;
    assign ctl.close  = close;
    assign ctl.full   = full;
    assign ctl.price  = price;
    assign ctl.qty    = qty;

    for (genvar j = 0; j < L; j++)
    begin : g_cell
        logic           occ;
        logic           l_ahead;
        plob_pkg::lvl_t l_lvl;
        plob_pkg::lvl_t r_lvl;

        assign occ = (plob_pkg::CNT_BITS'(j) < count_reg);
        if (j == 0)
        begin : g_first
            assign l_ahead = 1'b1;
            assign l_lvl   = lvl[0];
        end
        else
        begin : g_mid
            assign l_ahead = stat[j-1].ahead;
            assign l_lvl   = lvl[j-1];
        end
        if (j == L - 1)
        begin : g_last
            assign r_lvl = lvl[j];
        end
        else
        begin : g_inner
            assign r_lvl = lvl[j+1];
        end

        plob_cell u_cell
        (
            .clk        (clk),
            .ctl        (ctl),
            .occupied   (occ),
            .left_ahead (l_ahead),
            .left_lvl   (l_lvl),
            .right_lvl  (r_lvl),
            .stat       (stat[j]),
            .lvl        (lvl[j]),
            .lvl_next   (lvl_nx[j])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (en)
        begin
            if (!remove && !hit && !full)
            begin
                count_next = count_reg + 1'b1;
            end
            else if (remove && close)
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    assign best_next = (count_next != '0) ? lvl_nx[0].price : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end
endmodule

// ----- tb/tb_price_level_order_book_core.sv -----
// Testbench for the price level order book core: directed table, random traffic, scoreboard.
`timescale 1ns / 100ps
module tb_price_level_order_book_core;

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;
    localparam logic SIDE_ASK    = 1'b0;
    localparam logic SIDE_BID    = 1'b1;
    localparam logic [23:0] PRICE_MAX = 24'hFFFFFF;
    localparam logic [19:0] QTY_MAX   = 20'hFFFFF;
    localparam logic [31:0] TOTAL_SAT = 32'hFFFFFFFF;

    // Members run from the highest bits down, so best_bid lands in the lowest bits.
    typedef struct packed {
        plob_pkg::status_t status;
        logic [6:0]        ask_count;
        logic [6:0]        bid_count;
        logic [24:0]       spread;
        logic [23:0]       best_ask;
        logic [23:0]       best_bid;
    } book_view_t;

    typedef struct {
        logic        kind;
        logic        side;
        logic [23:0] price;
        logic [19:0] qty;
        logic        typed;
        book_view_t  view;
    } order_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [1:0]  s_axis_tuser;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;

    // Book mirror: one table per side, index 0 is the ask side, 1 the bid side.
    logic [23:0] level_price [2][plob_pkg::LEVELS];
    logic [31:0] level_total [2][plob_pkg::LEVELS];
    int          levels_open [2];

    book_view_t  pending_views[$];
    int          mismatches;
    bit          calm;
    order_row_t  rows[$];

    price_level_order_book_core u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [23:0] best_level(int sd, bit highest);
        logic [23:0] best;
        best = 24'd0;
        if (levels_open[sd] > 0)
        begin
            best = level_price[sd][0];
            for (int i = 1; i < levels_open[sd]; i++)
            begin
                if (highest ? (level_price[sd][i] > best) : (level_price[sd][i] < best))
                    best = level_price[sd][i];
            end
        end
        return best;
    endfunction

    // Applies one request to the mirror and returns the book view it leaves.
    function automatic book_view_t apply_order(logic kind, logic side, logic [23:0] price,
                                               logic [19:0] qty);
        book_view_t v;
        int sd;
        int slot;
        int last;
        logic [32:0] sum;
        sd = side ? 1 : 0;
        slot = -1;
        v.status = plob_pkg::ST_OK;
        for (int i = 0; i < levels_open[sd]; i++)
        begin
            if (slot < 0 && level_price[sd][i] == price)
                slot = i;
        end
        if (kind == KIND_ADD)
        begin
            if (slot < 0 && levels_open[sd] >= plob_pkg::LEVELS)
                v.status = plob_pkg::ST_FULL;
            else
            begin
                if (slot < 0)
                begin
                    slot = levels_open[sd];
                    level_price[sd][slot] = price;
                    level_total[sd][slot] = 32'd0;
                    levels_open[sd]++;
                end
                sum = {1'b0, level_total[sd][slot]} + qty;
                level_total[sd][slot] = sum[32] ? TOTAL_SAT : sum[31:0];
            end
        end
        else if (slot < 0)
            v.status = plob_pkg::ST_ABSENT;
        else if (qty >= level_total[sd][slot])
        begin
            last = levels_open[sd] - 1;
            level_price[sd][slot] = level_price[sd][last];
            level_total[sd][slot] = level_total[sd][last];
            levels_open[sd] = last;
        end
        else
            level_total[sd][slot] -= qty;
        v.best_bid  = best_level(1, 1'b1);
        v.best_ask  = best_level(0, 1'b0);
        v.spread    = (v.best_bid == 0 || v.best_ask == 0) ? 25'd0 :
                      {1'b0, v.best_ask} - {1'b0, v.best_bid};
        v.bid_count = levels_open[1][6:0];
        v.ask_count = levels_open[0][6:0];
        return v;
    endfunction

    task automatic idle_sender();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return;
        s_axis_tvalid <= 1'b0;
        if (r < 92)
            repeat ($urandom_range(1, 3)) @(posedge clk);
        else
            repeat ($urandom_range(10, 40)) @(posedge clk);
    endtask

    task automatic send_order(logic kind, logic side, logic [23:0] price, logic [19:0] qty,
                              bit typed, book_view_t typed_view);
        book_view_t v;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {side, kind};
        s_axis_tdata  <= {4'd0, qty, price};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        v = apply_order(kind, side, price, qty);
        pending_views.push_back(typed ? typed_view : v);
        idle_sender();
    endtask

    task automatic random_order(int mode);
        book_view_t none;
        logic kind;
        logic side;
        logic [23:0] price;
        logic [19:0] qty;
        int r;
        none = '0;
        side = 1'($urandom_range(0, 1));
        kind = ($urandom_range(0, 99) < 55) ? KIND_ADD : KIND_REMOVE;
        r = $urandom_range(0, 99);
        // Prices mostly come from two overlapping pools so levels get hit again.
        if (r < 85)
            price = (side ? 24'd1000 : 24'd1050) + 24'($urandom_range(0, 79));
        else
            price = 24'($urandom());
        r = $urandom_range(0, 99);
        if (r < 70)
            qty = 20'($urandom_range(1, 50));
        else if (r < 90)
            qty = 20'($urandom());
        else
            qty = QTY_MAX;
        if (mode == 1)
        begin
            kind  = KIND_ADD;
            price = (side ? 24'd200000 : 24'd300000) + 24'($urandom_range(0, 2000));
        end
        send_order(kind, side, price, qty, 1'b0, none);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_views.size() != 0)
            @(posedge clk);
    endtask

    function automatic book_view_t view_of(logic [23:0] bb, logic [23:0] ba, logic [24:0] sp,
                                           int nb, int na, plob_pkg::status_t st);
        book_view_t v;
        v.best_bid  = bb;
        v.best_ask  = ba;
        v.spread    = sp;
        v.bid_count = nb[6:0];
        v.ask_count = na[6:0];
        v.status    = st;
        return v;
    endfunction

    task automatic add_row(logic kind, logic side, logic [23:0] price, logic [19:0] qty,
                           bit typed, book_view_t v);
        order_row_t row;
        row.kind  = kind;
        row.side  = side;
        row.price = price;
        row.qty   = qty;
        row.typed = typed;
        row.view  = v;
        rows.push_back(row);
    endtask

    // Ready side: random stalls, with calm stretches.
    initial
    begin
        int r;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            r = $urandom_range(0, 99);
            if (calm || r < 55)
                m_axis_tready <= 1'b1;
            else if (r < 92)
                m_axis_tready <= 1'b0;
            else
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        book_view_t got;
        book_view_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = book_view_t'(m_axis_tdata[88:0]);
            if (pending_views.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result %h", got);
            end
            else
            begin
                want = pending_views.pop_front();
                if (got !== want || m_axis_tdata[95:89] !== 7'd0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("bid %h/%h ask %h/%h spr %h/%h n %0d,%0d/%0d,%0d st %0d/%0d",
                                 want.best_bid, got.best_bid, want.best_ask, got.best_ask,
                                 want.spread, got.spread, want.bid_count, want.ask_count,
                                 got.bid_count, got.ask_count, want.status, got.status);
                end
            end
        end
    end

    initial
    begin
        #50_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        book_view_t none;
        none = '0;
        mismatches = 0;
        calm = 1'b0;
        levels_open[0] = 0;
        levels_open[1] = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = 2'd0;
        s_axis_tdata = 48'd0;

        add_row(KIND_REMOVE, SIDE_BID, 24'd100, 20'd5, 1'b1,
                view_of('0, '0, '0, 0, 0, plob_pkg::ST_ABSENT));
        add_row(KIND_ADD, SIDE_BID, PRICE_MAX, QTY_MAX, 1'b1,
                view_of(PRICE_MAX, '0, '0, 1, 0, plob_pkg::ST_OK));
        add_row(KIND_ADD, SIDE_ASK, 24'd1, 20'd1, 1'b1,
                view_of(PRICE_MAX, 24'd1, 25'd1 - 25'hFFFFFF, 1, 1, plob_pkg::ST_OK));
        add_row(KIND_REMOVE, SIDE_BID, PRICE_MAX, QTY_MAX, 1'b1,
                view_of('0, 24'd1, '0, 0, 1, plob_pkg::ST_OK));
        // A zero price with zero quantity still opens a level, and removing zero closes it.
        add_row(KIND_ADD, SIDE_BID, 24'd0, 20'd0, 1'b1,
                view_of('0, 24'd1, '0, 1, 1, plob_pkg::ST_OK));
        add_row(KIND_REMOVE, SIDE_BID, 24'd0, 20'd0, 1'b1,
                view_of('0, 24'd1, '0, 0, 1, plob_pkg::ST_OK));
        add_row(KIND_ADD, SIDE_BID, 24'd500, 20'd10, 1'b0, none);
        add_row(KIND_ADD, SIDE_BID, 24'd700, 20'd3, 1'b0, none);
        add_row(KIND_ADD, SIDE_BID, 24'd700, 20'd4, 1'b0, none);
        add_row(KIND_REMOVE, SIDE_BID, 24'd700, 20'd1, 1'b0, none);
        add_row(KIND_ADD, SIDE_ASK, 24'd800, 20'd7, 1'b0, none);
        add_row(KIND_ADD, SIDE_ASK, 24'd600, 20'd2, 1'b0, none);
        add_row(KIND_REMOVE, SIDE_ASK, 24'd1, 20'd1, 1'b0, none);
        add_row(KIND_REMOVE, SIDE_BID, 24'd700, 20'd6, 1'b0, none);
        add_row(KIND_ADD, SIDE_ASK, 24'd0, 20'd4, 1'b0, none);
        add_row(KIND_REMOVE, SIDE_ASK, 24'd0, QTY_MAX, 1'b0, none);
        add_row(KIND_ADD, SIDE_BID, 24'd650, QTY_MAX, 1'b0, none);
        add_row(KIND_REMOVE, SIDE_ASK, 24'd900, 20'd1, 1'b0, none);
        add_row(KIND_REMOVE, SIDE_ASK, 24'd600, 20'd1, 1'b0, none);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_order(rows[i].kind, rows[i].side, rows[i].price, rows[i].qty,
                       rows[i].typed, rows[i].view);
        wait_drained();

        repeat (200) random_order(0);
        calm = 1'b1;
        repeat (80) random_order(0);
        calm = 1'b0;
        // Fill both sides past capacity so new levels get dropped.
        repeat (150) random_order(1);
        wait_drained();
        repeat (150) random_order(0);
        repeat (100) random_order(0);

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_views.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+sv
sv/plob_pkg.sv
sv/plob_cell.sv
sv/plob_side.sv
sv/price_level_order_book_core.sv
tb/tb_price_level_order_book_core.sv
